// File: sv/text_encoding_sniffer_top_assert.svh
// Assertion macros used by the checker file of the encoding sniffer.
`ifndef TEXT_ENCODING_SNIFFER_TOP_ASSERT_SVH
`define TEXT_ENCODING_SNIFFER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, quiet during reset.
`define TES_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, quiet during reset.
`define TES_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/tes_pkg.sv
`default_nettype none

package tes_pkg;

  // One byte of the buffer, with the end-of-buffer mark
  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } octet_t;

  // One verdict for a whole buffer
  typedef struct packed {
    logic [2:0] encoding;
    logic       has_bom;
  } verdict_t;

  // Encoding codes
  localparam logic [2:0] ENC_UTF8     = 3'd0;
  localparam logic [2:0] ENC_UTF8_BOM = 3'd1;
  localparam logic [2:0] ENC_UTF16_LE = 3'd2;
  localparam logic [2:0] ENC_UTF16_BE = 3'd3;
  localparam logic [2:0] ENC_ANSI     = 3'd4;

  // Byte order mark bytes
  localparam logic [7:0] BOM_EF = 8'hEF;
  localparam logic [7:0] BOM_BB = 8'hBB;
  localparam logic [7:0] BOM_BF = 8'hBF;
  localparam logic [7:0] BOM_FF = 8'hFF;
  localparam logic [7:0] BOM_FE = 8'hFE;

  // UTF-8 lead and continuation masks and patterns
  localparam logic [7:0] MASK_CONT  = 8'hC0;
  localparam logic [7:0] PAT_CONT   = 8'h80;
  localparam logic [7:0] MASK_LEAD2 = 8'hE0;
  localparam logic [7:0] PAT_LEAD2  = 8'hC0;
  localparam logic [7:0] MASK_LEAD3 = 8'hF0;
  localparam logic [7:0] PAT_LEAD3  = 8'hE0;
  localparam logic [7:0] MASK_LEAD4 = 8'hF8;
  localparam logic [7:0] PAT_LEAD4  = 8'hF0;

  // Saturated byte count
  localparam logic [1:0] POS_FULL = 2'd3;

endpackage

`default_nettype wire

// File: sv/text_encoding_sniffer_top.sv
`default_nettype none

// Byte-serial text encoding sniffer: takes one byte of a buffer per clock on
// the octet channel while it is not stalled and, for the byte marked
// last_byte, gives one verdict on the verdict channel (encoding code and BOM
// flag). A byte order mark among the first bytes wins (EF BB BF, then FF FE,
// then FE FF); otherwise a loose UTF-8 check decides between UTF-8 and ANSI.
// A buffer of a single byte is always given UTF-8. The last byte passes from
// the input register into the verdict register, which holds the verdict until
// it is taken. The octet channel stalls only while a last byte waits in the
// input register and the verdict register still holds a stalled verdict. All
// sniffer state clears after each last byte, so buffers may follow each other
// back to back.
module text_encoding_sniffer_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              octet_valid,
  output logic                   octet_stall,
  input  wire tes_pkg::octet_t   octet,
  output logic                   verdict_valid,
  input  wire logic              verdict_stall,
  output tes_pkg::verdict_t      verdict
);

  // Input register
  logic            s1_valid;
  tes_pkg::octet_t s1;

  // Sniffer state
  logic [7:0] head0;
  logic [7:0] head1;
  logic [7:0] head2;
  logic [1:0] pos;
  logic [1:0] pend;
  logic       still_valid;

  // Next values
  logic [7:0] head0_next;
  logic [7:0] head1_next;
  logic [7:0] head2_next;
  logic [1:0] pos_next;
  logic [1:0] pend_next;
  logic       still_valid_next;
  tes_pkg::verdict_t verdict_next;

  logic [7:0] b;
  logic       s1_fire;
  logic       out_free;

  assign b = s1.data_byte;

  // Advance the input register unless a last item is blocked by the verdict slot
  assign out_free    = !verdict_valid || !verdict_stall;
  assign s1_fire     = s1_valid && (!s1.last_byte || out_free);
  assign octet_stall = s1_valid && !s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!octet_stall) begin
      s1_valid <= octet_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!octet_stall && octet_valid) begin
      s1 <= octet;
    end
  end

  // Capture the head bytes and count position, saturating
  always_comb begin
    head0_next = head0;
    head1_next = head1;
    head2_next = head2;
    pos_next   = pos;
    case (pos)
      2'd0: begin
        head0_next = b;
        pos_next   = 2'd1;
      end
      2'd1: begin
        head1_next = b;
        pos_next   = 2'd2;
      end
      2'd2: begin
        head2_next = b;
        pos_next   = tes_pkg::POS_FULL;
      end
      default: begin
        pos_next = tes_pkg::POS_FULL;
      end
    endcase
  end

  // Run the loose UTF-8 check on this byte
  always_comb begin
    pend_next        = pend;
    still_valid_next = still_valid;
    if (still_valid) begin
      if (pend != 2'd0) begin
        if ((b & tes_pkg::MASK_CONT) == tes_pkg::PAT_CONT) begin
          pend_next = pend - 2'd1;
        end else begin
          still_valid_next = 1'b0;
        end
      end else if (b[7]) begin
        if ((b & tes_pkg::MASK_LEAD2) == tes_pkg::PAT_LEAD2) begin
          pend_next = 2'd1;
        end else if ((b & tes_pkg::MASK_LEAD3) == tes_pkg::PAT_LEAD3) begin
          pend_next = 2'd2;
        end else if ((b & tes_pkg::MASK_LEAD4) == tes_pkg::PAT_LEAD4) begin
          pend_next = 2'd3;
        end else begin
          still_valid_next = 1'b0;
        end
      end
    end
  end

  // Form the verdict from the updated state
  always_comb begin
    verdict_next.has_bom = 1'b0;
    if (pos_next < 2'd2) begin
      verdict_next.encoding = tes_pkg::ENC_UTF8;
    end else if (pos_next == tes_pkg::POS_FULL && head0_next == tes_pkg::BOM_EF &&
                 head1_next == tes_pkg::BOM_BB && head2_next == tes_pkg::BOM_BF) begin
      verdict_next.encoding = tes_pkg::ENC_UTF8_BOM;
      verdict_next.has_bom  = 1'b1;
    end else if (head0_next == tes_pkg::BOM_FF && head1_next == tes_pkg::BOM_FE) begin
      verdict_next.encoding = tes_pkg::ENC_UTF16_LE;
      verdict_next.has_bom  = 1'b1;
    end else if (head0_next == tes_pkg::BOM_FE && head1_next == tes_pkg::BOM_FF) begin
      verdict_next.encoding = tes_pkg::ENC_UTF16_BE;
      verdict_next.has_bom  = 1'b1;
    end else if (still_valid_next && pend_next == 2'd0) begin
      verdict_next.encoding = tes_pkg::ENC_UTF8;
    end else begin
      verdict_next.encoding = tes_pkg::ENC_ANSI;
    end
  end

  // Update state; clear it after the last item of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      head0       <= 8'd0;
      head1       <= 8'd0;
      head2       <= 8'd0;
      pos         <= 2'd0;
      pend        <= 2'd0;
      still_valid <= 1'b1;
    end else if (s1_fire) begin
      if (s1.last_byte) begin
        head0       <= 8'd0;
        head1       <= 8'd0;
        head2       <= 8'd0;
        pos         <= 2'd0;
        pend        <= 2'd0;
        still_valid <= 1'b1;
      end else begin
        head0       <= head0_next;
        head1       <= head1_next;
        head2       <= head2_next;
        pos         <= pos_next;
        pend        <= pend_next;
        still_valid <= still_valid_next;
      end
    end
  end

  // Load the verdict register; drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_fire && s1.last_byte) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1.last_byte) begin
      verdict <= verdict_next;
    end
  end

endmodule

`default_nettype wire

// File: sv/tes_checker.sv
`default_nettype none

`include "text_encoding_sniffer_top_assert.svh"

module tes_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              octet_valid,
  input wire logic              octet_stall,
  input wire tes_pkg::octet_t   octet,
  input wire logic              verdict_valid,
  input wire logic              verdict_stall,
  input wire tes_pkg::verdict_t verdict
);

  // BOM flag agrees with the encoding code
  `TES_ASSERT_NOW(a_bom_matches_enc, verdict_valid, verdict.has_bom == ((verdict.encoding == tes_pkg::ENC_UTF8_BOM) || (verdict.encoding == tes_pkg::ENC_UTF16_LE) || (verdict.encoding == tes_pkg::ENC_UTF16_BE)), "has_bom disagrees with encoding")

  // Input stalls only under a full, stalled verdict slot
  `TES_ASSERT_NOW(a_stall_from_out, octet_stall, verdict_valid && verdict_stall, "octet stalled without verdict backpressure")

  // A stalled verdict holds
  `TES_ASSERT_NEXT(a_verdict_holds, verdict_valid && verdict_stall, verdict_valid && $stable(verdict), "stalled verdict changed")

endmodule

bind text_encoding_sniffer_top tes_checker u_tes_checker (.*);

`default_nettype wire
